// File: hw/rtl/banded_point_distance_stream_assert.svh
// Assertion macros used by the checker file of the point distance stream.
// Depends on a clk and an active-low rst_n in the scope of each use.
`ifndef BANDED_POINT_DISTANCE_STREAM_ASSERT_SVH
`define BANDED_POINT_DISTANCE_STREAM_ASSERT_SVH

// Holds in every cycle outside reset.
`define BPD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bpd_pkg.sv
// Shared types and constants of the banded point distance stream.
// No dependencies.
`default_nettype none
package bpd_pkg;

  localparam int MAX_WINDOW_DEF = 63;
  localparam int COORD_W        = 16;
  localparam int POINT_W        = 3 * COORD_W;
  localparam int LEN_W          = 6;
  localparam int CODE_W         = 16;
  localparam int SUM_W          = 34;
  localparam int ROOT_W         = 17;

  localparam logic [17:0] DIST_BIAS = 18'd10000;
  localparam logic [17:0] DIST_MAX  = 18'd65535;

  localparam logic [LEN_W-1:0] WINDOW_LEN_RST = 6'd63;

  // Register byte addresses.
  localparam logic [1:0] REG_WINDOW_LEN = 2'd0;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } point_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_CALC,
    ST_OUT,
    ST_STORE
  } seq_state_t;

  typedef enum logic [1:0] {
    U_IDLE,
    U_SQ,
    U_RT,
    U_FIN
  } unit_state_t;

endpackage
`default_nettype wire

// File: hw/rtl/bpd_if.sv
// Stream channel interfaces for points in and distances out.
// Depends on bpd_pkg.
`default_nettype none
interface bpd_in_if import bpd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] x_code;
  logic [COORD_W-1:0] y_code;
  logic [COORD_W-1:0] z_code;
  logic               chain_start;
  modport source (output valid, x_code, y_code, z_code, chain_start, input ready);
  modport sink   (input valid, x_code, y_code, z_code, chain_start, output ready);
endinterface

interface bpd_out_if import bpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] distance_code;
  logic [LEN_W-1:0]  back_offset;
  logic              run_last;
  modport source (output valid, distance_code, back_offset, run_last, input ready);
  modport sink   (input valid, distance_code, back_offset, run_last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/banded_point_distance_stream.sv
// Banded point distance stream: each point beat yields one distance beat per
// earlier point of its chain in the window, oldest first.
// Each distance passes through read, load, square/add of the three axes, the bit-serial
// root, round, hand back and output. A new point is taken only after every distance of
// the previous point has been handed out and the point stored, as the distance unit is
// shared. Reset (rst_n low, synchronous) empties the window; window_len 63.
`default_nettype none
module banded_point_distance_stream import bpd_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  bpd_in_if.sink           in_beat,
  bpd_out_if.source        out_beat,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(MAX_WINDOW);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_WINDOW - 1);

  seq_state_t        state_r, state_nxt;
  logic [LEN_W-1:0]  window_len_r, window_len_nxt;
  logic [LEN_W-1:0]  fill_r, fill_nxt;
  logic [SLOT_W-1:0] wslot_r, wslot_nxt;
  logic [LEN_W-1:0]  k_r, k_nxt;
  point_t            pt_r, pt_nxt;
  logic [CODE_W-1:0] dist_r, dist_nxt;

  logic              u_start;
  logic              u_done;
  logic [CODE_W-1:0] ucode;
  point_t            rd_pt;
  logic [LEN_W-1:0]  fill_eff, len;
  logic [LEN_W:0]    slot_sum;
  logic [SLOT_W-1:0] rslot;
  logic              ram_we;
  logic              cfg_wr;

  // Configuration port: one register, written on the access phase.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == REG_WINDOW_LEN);
  assign cfg_prdata = (cfg_paddr == REG_WINDOW_LEN) ? 32'(window_len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      window_len_r <= WINDOW_LEN_RST;
      fill_r       <= '0;
      wslot_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      window_len_r <= window_len_nxt;
      fill_r       <= fill_nxt;
      wslot_r      <= wslot_nxt;
    end
    k_r    <= k_nxt;
    pt_r   <= pt_nxt;
    dist_r <= dist_nxt;
  end

  // Compare count: window_len, clamped to the ring depth and to the fill.
  always_comb begin
    fill_eff = in_beat.chain_start ? '0 : fill_r;
    len      = (window_len_r > MAX_LEN) ? MAX_LEN : window_len_r;
    if (len > fill_eff) begin
      len = fill_eff;
    end
  end

  // Ring slot k points back: one compare and subtract wraps it.
  always_comb begin
    slot_sum = (LEN_W+1)'(wslot_r) + (LEN_W+1)'(MAX_WINDOW) - (LEN_W+1)'(k_r);
    if (slot_sum >= (LEN_W+1)'(MAX_WINDOW)) begin
      slot_sum = slot_sum - (LEN_W+1)'(MAX_WINDOW);
    end
    rslot = slot_sum[SLOT_W-1:0];
  end

  always_comb begin
    state_nxt      = state_r;
    window_len_nxt = cfg_wr ? cfg_pwdata[LEN_W-1:0] : window_len_r;
    fill_nxt       = fill_r;
    wslot_nxt      = wslot_r;
    k_nxt          = k_r;
    pt_nxt         = pt_r;
    dist_nxt       = dist_r;
    u_start        = 1'b0;
    ram_we         = 1'b0;
    in_beat.ready  = 1'b0;
    out_beat.valid = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_beat.ready = 1'b1;
        if (in_beat.valid) begin
          pt_nxt    = '{x: in_beat.x_code, y: in_beat.y_code, z: in_beat.z_code};
          fill_nxt  = fill_eff;
          k_nxt     = len;
          state_nxt = (len == '0) ? ST_STORE : ST_READ;
        end
      end
      ST_READ:  state_nxt = ST_LOAD;
      ST_LOAD: begin
        // Read data lands now; hand it to the distance unit.
        u_start   = 1'b1;
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        if (u_done) begin
          dist_nxt  = ucode;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_beat.valid = 1'b1;
        if (out_beat.ready) begin
          k_nxt     = k_r - LEN_W'(1);
          state_nxt = (k_r == LEN_W'(1)) ? ST_STORE : ST_READ;
        end
      end
      ST_STORE: begin
        // Write the point into the ring and advance.
        ram_we    = 1'b1;
        wslot_nxt = (wslot_r == LAST_SLOT) ? '0 : wslot_r + SLOT_W'(1);
        if (fill_r < MAX_LEN) begin
          fill_nxt = fill_r + LEN_W'(1);
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_beat.distance_code = dist_r;
  assign out_beat.back_offset   = k_r;
  assign out_beat.run_last      = (k_r == LEN_W'(1));

  bpd_ram #(
    .WIDTH (POINT_W),
    .DEPTH (MAX_WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wslot_r),
    .wdata (pt_r),
    .raddr (rslot),
    .rdata (rd_pt)
  );

  bpd_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .start (u_start),
    .pa    (rd_pt),
    .pb    (pt_r),
    .done  (u_done),
    .code  (ucode)
  );
endmodule
`default_nettype wire

// File: hw/rtl/bpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bpd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 63,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/bpd_dist.sv
// Shared distance unit: squares three deltas on one multiplier, then takes a
// bit-serial rounded square root. Depends on bpd_pkg.
`default_nettype none
module bpd_dist import bpd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire point_t            pa,
  input  wire point_t            pb,
  output logic                   done,
  output logic      [CODE_W-1:0] code
);
  unit_state_t        state_r, state_nxt;
  point_t             a_r, a_nxt, b_r, b_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic [31:0]        sq_r, sq_nxt;
  logic [SUM_W-1:0]   acc_r, acc_nxt;
  logic [SUM_W-1:0]   rem_r, rem_nxt;
  logic [SUM_W:0]     res_r, res_nxt;
  logic [SUM_W-1:0]   bit_r, bit_nxt;
  logic [CODE_W-1:0]  code_r, code_nxt;
  logic               done_r, done_nxt;

  logic [COORD_W-1:0] ca, cb, diff;
  logic [SUM_W:0]     trial;
  logic [17:0]        rnd, biased;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    idx_r  <= idx_nxt;
    sq_r   <= sq_nxt;
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
    bit_r  <= bit_nxt;
    code_r <= code_nxt;
  end

  always_comb begin
    case (idx_r)
      2'd0:    begin ca = a_r.x; cb = b_r.x; end
      2'd1:    begin ca = a_r.y; cb = b_r.y; end
      default: begin ca = a_r.z; cb = b_r.z; end
    endcase
    diff   = (ca >= cb) ? ca - cb : cb - ca;
    trial  = res_r + {1'b0, bit_r};
    rnd    = {1'b0, res_r[ROOT_W-1:0]} +
             18'((rem_r > SUM_W'(res_r[ROOT_W-1:0])) ? 1 : 0);
    biased = rnd + DIST_BIAS;

    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    idx_nxt   = idx_r;
    sq_nxt    = sq_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    res_nxt   = res_r;
    bit_nxt   = bit_r;
    code_nxt  = code_r;
    done_nxt  = 1'b0;

    unique case (state_r)
      U_IDLE: begin
        if (start) begin
          a_nxt     = pa;
          b_nxt     = pb;
          idx_nxt   = 2'd0;
          acc_nxt   = '0;
          state_nxt = U_SQ;
        end
      end
      U_SQ: begin
        // Square one axis per cycle, add the previous square behind it.
        sq_nxt  = {16'b0, diff} * {16'b0, diff};
        acc_nxt = acc_r + ((idx_r != 2'd0) ? SUM_W'(sq_r) : '0);
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd3) begin
          rem_nxt   = acc_r + SUM_W'(sq_r);
          res_nxt   = '0;
          bit_nxt   = SUM_W'(1) << (SUM_W - 2);
          state_nxt = U_RT;
        end
      end
      U_RT: begin
        if ({1'b0, rem_r} >= trial) begin
          rem_nxt = rem_r - trial[SUM_W-1:0];
          res_nxt = (res_r >> 1) + {1'b0, bit_r};
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          state_nxt = U_FIN;
        end
      end
      U_FIN: begin
        // Round up when the remainder exceeds the root, then bias and clamp.
        code_nxt  = (biased > DIST_MAX) ? CODE_W'(DIST_MAX) : biased[CODE_W-1:0];
        done_nxt  = 1'b1;
        state_nxt = U_IDLE;
      end
      default: state_nxt = U_IDLE;
    endcase
  end

  assign done = done_r;
  assign code = code_r;
endmodule
`default_nettype wire

// File: hw/rtl/bpd_checker.sv
// Port-level checks of the point distance stream, bound to the top level.
// Depends on banded_point_distance_stream_assert.svh.
`default_nettype none
`include "banded_point_distance_stream_assert.svh"
module bpd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] distance_code,
  input wire logic [5:0]  back_offset,
  input wire logic        run_last
);
  `BPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "distance beat dropped")
  `BPD_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "point taken while busy")
  `BPD_ASSERT_ALWAYS(a_one_item, !(out_valid && in_ready), "point taken with beat pending")
  `BPD_ASSERT_ALWAYS(a_out_range,
      !out_valid || (distance_code >= 16'd10000 && back_offset != 6'd0 &&
      (run_last == (back_offset == 6'd1))), "distance beat out of range")
  `BPD_ASSERT_NEXT(a_last_ends, out_valid && out_ready && run_last, !out_valid,
      "beat after last of run")
endmodule

bind banded_point_distance_stream bpd_checker u_bpd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_beat.valid),
  .in_ready      (in_beat.ready),
  .out_valid     (out_beat.valid),
  .out_ready     (out_beat.ready),
  .distance_code (out_beat.distance_code),
  .back_offset   (out_beat.back_offset),
  .run_last      (out_beat.run_last)
);
`default_nettype wire
